### sv/brr_pkg.sv
// brr_pkg: shared types and constants for the BRR ADPCM decoder.
// No dependencies; every other file of the decoder but brr_if imports it.
package brr_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int POS_W      = 4;
    localparam int DATA_BYTES = 8;
    localparam int ACC_W      = 22;
    localparam logic [3:0] SHIFT_MAX = 4'hC;

    localparam logic [1:0] FLT_NONE = 2'd0;
    localparam logic [1:0] FLT_ONE  = 2'd1;
    localparam logic [1:0] FLT_TWO  = 2'd2;
    localparam logic [1:0] FLT_THREE = 2'd3;

    localparam logic signed [ACC_W-1:0] SAT_MIN  = -ACC_W'(32'sh8000);
    localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'(32'sh7FFF);
    localparam logic signed [ACC_W-1:0] BIG_NEG  = -ACC_W'(32'sd2048);

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] shift;
        logic [1:0] filter;
        logic       end_bit;
        logic       loop_bit;
        logic       block_last;
        logic       clear_hist;
    } brr_item_t;

endpackage

### sv/brr_if.sv
// brr_if: valid/ready channel interfaces for the decoder input bytes and
// output samples. Depends on nothing.
interface brr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_sound;

    modport source (output valid, data_byte, start_of_sound, input ready);
    modport sink   (input valid, data_byte, start_of_sound, output ready);
endinterface

interface brr_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last_in_run;
    logic               last_of_block;
    logic               end_flag;
    logic               loop_flag;

    modport source (output valid, sample, last_in_run, last_of_block, end_flag, loop_flag,
                    input ready);
    modport sink   (input valid, sample, last_in_run, last_of_block, end_flag, loop_flag,
                    output ready);
endinterface

### sv/brr_front.sv
// brr_front: accepts stream bytes, tracks the block position, latches header
// fields and pushes data bytes into the queue. Depends on brr_pkg, brr_if.
module brr_front (
    input  logic              clk,
    input  logic              rst_n,
    brr_in_if.sink            byte_in,
    input  logic              q_full,
    output logic              push,
    output brr_pkg::brr_item_t push_item
);
    import brr_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       shift_reg, shift_next;
    logic [1:0]       filter_reg, filter_next;
    logic             end_reg, end_next;
    logic             loop_reg, loop_next;
    logic             clr_reg, clr_next;
    logic             accept;
    logic             is_header;
    logic             is_last;

    assign byte_in.ready = !q_full;
    assign accept    = byte_in.valid && byte_in.ready;
    assign is_header = byte_in.start_of_sound || (pos_reg == '0)
                       || (pos_reg > POS_W'(DATA_BYTES));
    assign is_last   = (pos_reg == POS_W'(DATA_BYTES));
    assign push      = accept && !is_header;

    always_comb
    begin
        push_item.data       = byte_in.data_byte;
        push_item.shift      = shift_reg;
        push_item.filter     = filter_reg;
        push_item.end_bit    = end_reg;
        push_item.loop_bit   = loop_reg;
        push_item.block_last = is_last;
        push_item.clear_hist = clr_reg;
    end

    always_comb
    begin
        pos_next    = pos_reg;
        shift_next  = shift_reg;
        filter_next = filter_reg;
        end_next    = end_reg;
        loop_next   = loop_reg;
        clr_next    = clr_reg;
        if (accept)
        begin
            if (is_header)
            begin
                shift_next  = byte_in.data_byte[7:4];
                filter_next = byte_in.data_byte[3:2];
                loop_next   = byte_in.data_byte[1];
                end_next    = byte_in.data_byte[0];
                pos_next    = POS_W'(1);
                if (byte_in.start_of_sound)
                begin
                    clr_next = 1'b1;
                end
            end
            else
            begin
                clr_next = 1'b0;
                pos_next = is_last ? '0 : pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            shift_reg  <= '0;
            filter_reg <= '0;
            end_reg    <= 1'b0;
            loop_reg   <= 1'b0;
            clr_reg    <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            shift_reg  <= shift_next;
            filter_reg <= filter_next;
            end_reg    <= end_next;
            loop_reg   <= loop_next;
            clr_reg    <= clr_next;
        end
    end

endmodule

### sv/brr_queue.sv
// brr_queue: small FIFO of decoded-header data items between front and back.
// Depends on brr_pkg.
module brr_queue #(
    parameter int DEPTH = brr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  brr_pkg::brr_item_t         push_item,
    input  logic                       pop,
    output brr_pkg::brr_item_t         head,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import brr_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    brr_item_t         mem [DEPTH];
    logic [PW-1:0]     wr_reg, wr_next;
    logic [PW-1:0]     rd_reg, rd_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
    assign head    = mem[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### sv/brr_back.sv
// brr_back: decodes the two nibbles of each queued byte, applies the
// prediction filter and clamp, and holds the output register.
// Depends on brr_pkg, brr_if.
module brr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  brr_pkg::brr_item_t head,
    input  logic              empty,
    output logic              pop,
    brr_out_if.source         sample_out
);
    import brr_pkg::*;

    logic signed [15:0]      prev_reg, older_reg;
    logic                    phase_reg;
    logic                    ovalid_reg;
    logic signed [15:0]      sample_reg;
    logic                    run_reg, blk_reg, end_reg, loop_reg;
    logic                    step;
    logic                    use_zero;
    logic [3:0]              nib;
    logic signed [ACC_W-1:0] n, base, s1, s2, pred, sum;
    logic signed [15:0]      sat;

    assign step = !empty && (!ovalid_reg || sample_out.ready);
    assign pop  = step && phase_reg;

    assign use_zero = head.clear_hist && !phase_reg;
    assign nib = phase_reg ? head.data[3:0] : head.data[7:4];
    assign n   = ACC_W'(signed'(nib));
    assign s1  = use_zero ? '0 : ACC_W'(prev_reg);
    assign s2  = use_zero ? '0 : ACC_W'(older_reg);

    always_comb
    begin
        if (head.shift <= SHIFT_MAX)
        begin
            base = (n <<< head.shift) >>> 1;
        end
        else
        begin
            base = nib[3] ? BIG_NEG : '0;
        end

        case (head.filter)
            FLT_NONE:  pred = '0;
            FLT_ONE:   pred = s1 + ((-s1) >>> 4);
            FLT_TWO:   pred = (s1 <<< 1) + ((-(s1 * 3)) >>> 5) - s2 + (s2 >>> 4);
            FLT_THREE: pred = (s1 <<< 1) + ((-(s1 * 13)) >>> 6) - s2 + ((s2 * 3) >>> 4);
            default:   pred = '0;
        endcase

        sum = base + pred;
        if (sum < SAT_MIN)
        begin
            sat = 16'sh8000;
        end
        else if (sum > SAT_MAX)
        begin
            sat = 16'sh7FFF;
        end
        else
        begin
            sat = sum[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            sample_reg <= sat;
            run_reg    <= phase_reg;
            blk_reg    <= phase_reg && head.block_last;
            end_reg    <= head.end_bit;
            loop_reg   <= head.loop_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            older_reg  <= '0;
            phase_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                older_reg  <= s1[15:0];
                prev_reg   <= sat;
                phase_reg  <= !phase_reg;
                ovalid_reg <= 1'b1;
            end
            else if (sample_out.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign sample_out.valid         = ovalid_reg;
    assign sample_out.sample        = sample_reg;
    assign sample_out.last_in_run   = run_reg;
    assign sample_out.last_of_block = blk_reg;
    assign sample_out.end_flag      = end_reg;
    assign sample_out.loop_flag     = loop_reg;

endmodule

### sv/brr_adpcm_decoder_top.sv
// brr_adpcm_decoder_top: BRR ADPCM decoder, front parser, item queue, back decoder.
// Depends on brr_pkg, brr_if, brr_front, brr_queue, brr_back.
//
//   channel     dir  payload                                           width
//   byte_in     in   data_byte, start_of_sound                         8+1
//   sample_out  out  sample, last_in_run, last_of_block, end/loop_flag 16+4
//
// A header byte is taken and yields nothing. A data byte yields two samples,
// one per cycle while the queue is not empty and the output is not stalled,
// through the shared filter/clamp path in the back unit. Input stalls only
// when the queue is full; output stalls hold the sample register. Reset
// clears position, header fields, history and the queue.
module brr_adpcm_decoder_top #(
    parameter int QUEUE_DEPTH = brr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    brr_in_if.sink     byte_in,
    brr_out_if.source  sample_out
);
    import brr_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    brr_item_t     push_item;
    brr_item_t     head;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    logic [CW-1:0] q_count;

    brr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    brr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty),
        .count     (q_count)
    );

    brr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (q_empty),
        .pop        (pop),
        .sample_out (sample_out)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_block_last: assert property (@(posedge clk) disable iff (!rst_n)
        sample_out.valid && sample_out.last_of_block |-> sample_out.last_in_run)
        else $error("block end flagged on first sample of a byte");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("push into full queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty && !$isunknown(head))
        else $error("pop from empty queue");

endmodule
